### design/arpc_pkg.sv
// Shared types and constants for the ARP cache table with aging.
package arpc_pkg;

    localparam int CACHE_ENTRIES = 64;
    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int IP_W = 32;
    localparam int MAC_W = 48;
    localparam int SEC_W = 32;
    localparam int TMO_W = 16;
    localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(15);
    localparam int WORD_W = IP_W + MAC_W + SEC_W;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_TICK   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_status;

endpackage

### design/arp_cache_table_with_aging.sv
// Top level of the ARP cache table with aging timeout.
//
//   Channel   Direction  Handshake              Payload
//   input     in         i_valid / o_ready      i_kind, i_ip_address, i_mac_address
//   result    out        o_valid / i_ready      o_hit, o_found_mac, o_table_full
//   config    in         i_cfg_valid / o_cfg_ready  i_cfg_timeout_seconds
//
// Every transaction walks all CACHE_ENTRIES slots through the single read port of
// the entry memory, one slot per cycle in ST_SCAN. After ST_DRAIN, ST_FINISH loads the
// result once the output register is free, and ST_IDLE then takes the next transaction.
// Reset is synchronous and active low; it clears the valid bits, the seconds counter
// and the timeout register to 15.
// A stalled result holds in the output register while the next item is scanned.
module arp_cache_table_with_aging (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_kind,
    input  logic [arpc_pkg::IP_W-1:0]  i_ip_address,
    input  logic [arpc_pkg::MAC_W-1:0] i_mac_address,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_hit,
    output logic [arpc_pkg::MAC_W-1:0] o_found_mac,
    output logic                       o_table_full,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [arpc_pkg::TMO_W-1:0] i_cfg_timeout_seconds
);

    arpc_pkg::t_cmd    cmd;
    arpc_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    arpc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    arpc_datapath u_datapath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_status              (status),
        .i_kind                (i_kind),
        .i_ip_address          (i_ip_address),
        .i_mac_address         (i_mac_address),
        .i_cfg_valid           (i_cfg_valid),
        .i_cfg_timeout_seconds (i_cfg_timeout_seconds),
        .i_ready               (i_ready),
        .o_valid               (o_valid),
        .o_hit                 (o_hit),
        .o_found_mac           (o_found_mac),
        .o_table_full          (o_table_full)
    );

endmodule

### design/arpc_ctrl.sv
// Controller state machine that sequences the table scan for each transaction.
module arpc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  arpc_pkg::t_status  i_status,
    output arpc_pkg::t_cmd     o_cmd
);

    arpc_pkg::t_state r_state;
    arpc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arpc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            arpc_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = arpc_pkg::ST_SCAN;
                end
            end
            arpc_pkg::ST_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = arpc_pkg::ST_DRAIN;
                end
            end
            arpc_pkg::ST_DRAIN: begin
                n_state = arpc_pkg::ST_FINISH;
            end
            arpc_pkg::ST_FINISH: begin
                if (i_status.out_free) begin
                    n_state = arpc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = arpc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd = '0;
        case (r_state)
            arpc_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                o_cmd.load = i_valid;
            end
            arpc_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            arpc_pkg::ST_FINISH: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("Controller accepted a transaction while one was in progress.");

    a_load_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_status.out_free)
        else $error("Result loaded while the output register was occupied.");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.scan && i_status.scan_last) |=> (!o_cmd.scan && !o_ready))
        else $error("Scan did not stop after the last entry.");
`endif

endmodule

### design/arpc_datapath.sv
// Datapath with the entry memory, valid bits, seconds counter and result register.
module arpc_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  arpc_pkg::t_cmd                         i_cmd,
    output arpc_pkg::t_status                      o_status,
    input  logic [1:0]                             i_kind,
    input  logic [arpc_pkg::IP_W-1:0]              i_ip_address,
    input  logic [arpc_pkg::MAC_W-1:0]             i_mac_address,
    input  logic                                   i_cfg_valid,
    input  logic [arpc_pkg::TMO_W-1:0]             i_cfg_timeout_seconds,
    input  logic                                   i_ready,
    output logic                                   o_valid,
    output logic                                   o_hit,
    output logic [arpc_pkg::MAC_W-1:0]             o_found_mac,
    output logic                                   o_table_full
);

    logic [arpc_pkg::WORD_W-1:0]        r_mem [arpc_pkg::CACHE_ENTRIES];
    logic [arpc_pkg::WORD_W-1:0]        r_rd_word;
    logic [arpc_pkg::CACHE_ENTRIES-1:0] r_valid;
    logic [arpc_pkg::TMO_W-1:0]         r_timeout;
    logic [arpc_pkg::SEC_W-1:0]         r_now;
    logic [1:0]                         r_kind;
    logic [arpc_pkg::IP_W-1:0]          r_ip;
    logic [arpc_pkg::MAC_W-1:0]         r_mac;
    logic [arpc_pkg::IDX_W-1:0]         r_idx;
    logic [arpc_pkg::IDX_W-1:0]         r_p1_idx;
    logic                               r_p1_act;
    logic                               r_ins_done;
    logic                               r_hit;
    logic [arpc_pkg::MAC_W-1:0]         r_found;
    logic                               r_out_valid;
    logic                               r_out_hit;
    logic [arpc_pkg::MAC_W-1:0]         r_out_found;
    logic                               r_out_full;

    logic                               ins_take;
    logic [arpc_pkg::IP_W-1:0]          rd_ip;
    logic [arpc_pkg::MAC_W-1:0]         rd_mac;
    logic [arpc_pkg::SEC_W-1:0]         rd_stamp;
    logic [arpc_pkg::SEC_W-1:0]         age;
    logic                               p1_live;
    logic                               expire;
    logic                               match;

    assign rd_ip = r_rd_word[arpc_pkg::WORD_W-1 -: arpc_pkg::IP_W];
    assign rd_mac = r_rd_word[arpc_pkg::SEC_W +: arpc_pkg::MAC_W];
    assign rd_stamp = r_rd_word[arpc_pkg::SEC_W-1:0];
    assign age = r_now - rd_stamp;
    assign p1_live = r_p1_act && r_valid[r_p1_idx];
    assign expire = p1_live && (r_kind == arpc_pkg::KIND_TICK)
        && (age > {{(arpc_pkg::SEC_W-arpc_pkg::TMO_W){1'b0}}, r_timeout});
    assign match = p1_live && (r_kind == arpc_pkg::KIND_LOOKUP) && (rd_ip == r_ip);
    assign ins_take = i_cmd.scan && (r_kind == arpc_pkg::KIND_INSERT)
        && !r_ins_done && !r_valid[r_idx];

    assign o_status.scan_last = (r_idx == arpc_pkg::IDX_W'(arpc_pkg::CACHE_ENTRIES - 1));
    assign o_status.out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (ins_take) begin
            r_mem[r_idx] <= {r_ip, r_mac, r_now};
        end
        r_rd_word <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_ip <= i_ip_address;
            r_mac <= i_mac_address;
        end
        r_p1_idx <= r_idx;
        if (i_cmd.out_load) begin
            r_out_hit <= r_hit;
            r_out_found <= r_found;
            r_out_full <= (r_kind == arpc_pkg::KIND_INSERT) && !r_ins_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_timeout <= arpc_pkg::TIMEOUT_RESET;
            r_now <= '0;
            r_idx <= '0;
            r_p1_act <= 1'b0;
            r_ins_done <= 1'b0;
            r_hit <= 1'b0;
            r_found <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_p1_act <= i_cmd.scan;
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_timeout_seconds;
            end
            if (i_cmd.load) begin
                r_idx <= '0;
                r_ins_done <= 1'b0;
                r_hit <= 1'b0;
                r_found <= '0;
                if (i_kind == arpc_pkg::KIND_TICK) begin
                    r_now <= r_now + 1'b1;
                end
            end else if (i_cmd.scan) begin
                r_idx <= r_idx + 1'b1;
            end
            if (ins_take) begin
                r_valid[r_idx] <= 1'b1;
                r_ins_done <= 1'b1;
            end
            if (expire) begin
                r_valid[r_p1_idx] <= 1'b0;
            end
            if (match) begin
                r_hit <= 1'b1;
                r_found <= rd_mac;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_hit = r_out_hit;
    assign o_found_mac = r_out_found;
    assign o_table_full = r_out_full;

`ifndef SYNTHESIS
    a_load_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_idx == '0 && !r_hit && !r_ins_done))
        else $error("Scan state was not cleared when a transaction was taken.");

    a_hit_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_hit && r_out_full))
        else $error("Result reports both a hit and a full table.");

    a_miss_zero_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_hit) |-> (r_out_found == '0))
        else $error("Result carries a MAC without a hit.");
`endif

endmodule
